@@ hw/rtl/rbsi_pkg.sv @@
// Shared types and codes for the ray / box slab intersection block.
// Configuration register indexes and face codes. No dependencies.
package rbsi_pkg;

    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_LOW_X  = 3'd0;
    localparam t_cfg_idx REG_LOW_Y  = 3'd1;
    localparam t_cfg_idx REG_LOW_Z  = 3'd2;
    localparam t_cfg_idx REG_HIGH_X = 3'd3;
    localparam t_cfg_idx REG_HIGH_Y = 3'd4;
    localparam t_cfg_idx REG_HIGH_Z = 3'd5;

    typedef logic [2:0] t_face;

    localparam t_face FACE_NONE   = 3'd0;
    localparam t_face FACE_POS_Z  = 3'd1;
    localparam t_face FACE_NEG_Z  = 3'd2;
    localparam t_face FACE_POS_Y  = 3'd3;
    localparam t_face FACE_NEG_Y  = 3'd4;
    localparam t_face FACE_POS_X  = 3'd5;
    localparam t_face FACE_NEG_X  = 3'd6;

endpackage

@@ hw/rtl/rbsi_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Quotient = (num << FB) / den. No package dependencies.
module rbsi_div #(
    parameter int NW = 33,
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NW-1:0]     i_num,
    input  logic [DW-1:0]     i_den,
    output logic [NW+FB-1:0]  o_quo
);

    localparam int QW = NW + FB;

    logic [DW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_nq  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] w_rem;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_nq;
        logic [DW:0]   w_t;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem = '0;
            assign w_den = i_den;
            assign w_nq  = {i_num, {FB{1'b0}}};
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_den = r_den[k-1];
            assign w_nq  = r_nq[k-1];
        end

        assign w_t  = {w_rem, w_nq[QW-1]};
        assign w_ge = (w_t >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[k] <= {w_nq[QW-2:0], w_ge};
            end
        end

        if (k < QW - 1) begin : g_carry
            logic [DW:0] w_diff;
            assign w_diff = w_t - {1'b0, w_den};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
                    r_den[k] <= w_den;
                end
            end
        end
    end

    assign o_quo = r_nq[QW-1];

endmodule

@@ hw/rtl/rbsi_hitpt.sv @@
// Hit point for one axis: origin + dir * near, two register stages.
// Product truncated toward zero, capped, sum saturated. No dependencies.
module rbsi_hitpt #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [WORD_WIDTH-1:0] i_dir,
    input  logic [WORD_WIDTH-1:0] i_near,
    input  logic [WORD_WIDTH-1:0] i_orig,
    output logic [WORD_WIDTH-1:0] o_point
);

    localparam int W  = WORD_WIDTH;
    localparam int PW = 2 * W - FRAC_BITS;
    localparam int MW = ((PW > 63) ? PW : 63) + 2;

    logic [2*W-1:0] r_prod;
    logic           r_neg;
    logic [W-1:0]   r_orig;
    logic [W-1:0]   r_point;

    logic [W-1:0]   w_dm;
    logic [W-1:0]   w_nm;
    logic [MW-1:0]  w_sh;
    logic [MW-1:0]  w_cap;
    logic [MW-1:0]  w_val;
    logic [MW-1:0]  w_sum;
    logic           w_ovf;
    logic [W-1:0]   n_point;

    assign w_dm = i_dir[W-1]  ? W'(-i_dir)  : i_dir;
    assign w_nm = i_near[W-1] ? W'(-i_near) : i_near;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= (2*W)'(w_dm) * (2*W)'(w_nm);
            r_neg  <= i_dir[W-1] ^ i_near[W-1];
            r_orig <= i_orig;
        end
    end

    assign w_sh  = MW'(r_prod >> FRAC_BITS);
    assign w_cap = (w_sh > (MW'(1) << 62)) ? (MW'(1) << 62) : w_sh;
    assign w_val = r_neg ? MW'(-w_cap) : w_cap;
    assign w_sum = w_val + {{(MW-W){r_orig[W-1]}}, r_orig};
    assign w_ovf = !((&w_sum[MW-1:W-1]) || !(|w_sum[MW-1:W-1]));

    always_comb begin
        if (w_ovf) begin
            n_point = w_sum[MW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            n_point = w_sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_point <= n_point;
        end
    end

    assign o_point = r_point;

endmodule

@@ hw/rtl/ray_box_slab_intersect.sv @@
// Top level of the ray / axis-aligned box slab intersection block.
// Uses rbsi_pkg, rbsi_div (six pipelined dividers) and rbsi_hitpt.
//
// Usage:
//   Slave stream takes one ray per word: origin x,y,z then direction x,y,z,
//   signed fixed point. Master stream gives one result word per ray: hit,
//   entry distance, hit point x,y,z and face code. All fields are zero on
//   a miss. The box corners sit in six registers on the write port
//   (index 0..2 low x,y,z, 3..5 high x,y,z); write them only while idle.
//   Throughput: one ray per cycle while the receiver does not stall. The
//   pipeline depth is set by the dividers, which resolve one quotient bit
//   per stage.
//   The whole pipeline advances when the output register is empty or taken;
//   a receiver stall freezes every stage, and the slave tready drops with
//   it, so nothing is lost or repeated. Reset clears all valid bits and
//   loads the unit box (corners 0 and 1.0).
module ray_box_slab_intersect #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  rbsi_pkg::t_cfg_idx       i_cfg_idx,
    input  logic [WORD_WIDTH-1:0]    i_cfg_data,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // orig_x, orig_y, orig_z, dir_x, dir_y, dir_z, zero fill
    input  logic [((6*WORD_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // hit, t_entry, point_x, point_y, point_z, face, zero fill
    output logic [((4*WORD_WIDTH+4+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int W      = WORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int NW     = W + 1;
    localparam int QW     = NW + F;
    localparam int OUT_B  = 4 * W + 4;
    localparam int OUT_TW = ((OUT_B + 7) / 8) * 8;
    localparam int SW     = 6 * W + 10;
    localparam int S_NLO  = 6 * W;
    localparam int S_NHI  = 6 * W + 3;
    localparam int S_DZ   = 6 * W + 6;
    localparam int S_FAIL = 6 * W + 9;

    localparam logic [W-1:0]  TMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0]  TMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [QW-1:0] QLIM = QW'(1) << (W - 1);

    logic [W-1:0] r_box_lo [3];
    logic [W-1:0] r_box_hi [3];

    logic w_en;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_box_lo[a] <= '0;
                r_box_hi[a] <= W'(1) << F;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbsi_pkg::REG_LOW_X:  r_box_lo[0] <= i_cfg_data;
                rbsi_pkg::REG_LOW_Y:  r_box_lo[1] <= i_cfg_data;
                rbsi_pkg::REG_LOW_Z:  r_box_lo[2] <= i_cfg_data;
                rbsi_pkg::REG_HIGH_X: r_box_hi[0] <= i_cfg_data;
                rbsi_pkg::REG_HIGH_Y: r_box_hi[1] <= i_cfg_data;
                rbsi_pkg::REG_HIGH_Z: r_box_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage P: slab numerators, magnitudes, parallel test
    logic          r_p_valid;
    logic [NW-1:0] r_p_nlo [3];
    logic [NW-1:0] r_p_nhi [3];
    logic [W-1:0]  r_p_dm  [3];
    logic [SW-1:0] r_p_side;

    logic [NW-1:0] n_nlo [3];
    logic [NW-1:0] n_nhi [3];
    logic [W-1:0]  n_dm  [3];
    logic [SW-1:0] n_side;

    always_comb begin
        logic [W-1:0]  o;
        logic [W-1:0]  d;
        logic [NW-1:0] dl;
        logic [NW-1:0] dh;
        logic          fail;
        fail   = 1'b0;
        n_side = '0;
        n_side[6*W-1:0] = i_s_axis_tdata[6*W-1:0];
        for (int a = 0; a < 3; a++) begin
            o  = i_s_axis_tdata[a*W +: W];
            d  = i_s_axis_tdata[(3+a)*W +: W];
            dl = {r_box_lo[a][W-1], r_box_lo[a]} - {o[W-1], o};
            dh = {r_box_hi[a][W-1], r_box_hi[a]} - {o[W-1], o};
            n_nlo[a] = dl[W] ? NW'(-dl) : dl;
            n_nhi[a] = dh[W] ? NW'(-dh) : dh;
            n_dm[a]  = d[W-1] ? W'(-d) : d;
            n_side[S_NLO + a] = dl[W] ^ d[W-1];
            n_side[S_NHI + a] = dh[W] ^ d[W-1];
            n_side[S_DZ + a]  = (d == '0);
            if ((d == '0) && (($signed(o) < $signed(r_box_lo[a])) ||
                              ($signed(o) > $signed(r_box_hi[a])))) begin
                fail = 1'b1;
            end
        end
        n_side[S_FAIL] = fail;
    end

    assign w_en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_nlo  <= n_nlo;
            r_p_nhi  <= n_nhi;
            r_p_dm   <= n_dm;
            r_p_side <= n_side;
        end
    end

    // dividers and matching delay line
    logic [QW-1:0] w_qlo [3];
    logic [QW-1:0] w_qhi [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbsi_div #(.NW(NW), .DW(W), .FB(F)) u_div_lo (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_p_nlo[a]),
            .i_den (r_p_dm[a]),
            .o_quo (w_qlo[a])
        );
        rbsi_div #(.NW(NW), .DW(W), .FB(F)) u_div_hi (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_p_nhi[a]),
            .i_den (r_p_dm[a]),
            .o_quo (w_qhi[a])
        );
    end

    logic          r_dl_valid [QW];
    logic [SW-1:0] r_dl_side  [QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) r_dl_valid[k] <= 1'b0;
        end else if (w_en) begin
            r_dl_valid[0] <= r_p_valid;
            for (int k = 1; k < QW; k++) r_dl_valid[k] <= r_dl_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_side[0] <= r_p_side;
            for (int k = 1; k < QW; k++) r_dl_side[k] <= r_dl_side[k-1];
        end
    end

    // stage Q: sign and saturate quotients
    logic          r_q_valid;
    logic [W-1:0]  r_q_t1 [3];
    logic [W-1:0]  r_q_t2 [3];
    logic [SW-1:0] r_q_side;

    function automatic logic [W-1:0] f_sat(input logic [QW-1:0] q, input logic neg);
        logic sat;
        sat = (q > QLIM) || (!neg && (q == QLIM));
        if (sat) return neg ? TMIN : TMAX;
        return neg ? W'(-q[W-1:0]) : q[W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (w_en) begin
            r_q_valid <= r_dl_valid[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_q_t1[a] <= f_sat(w_qlo[a], r_dl_side[QW-1][S_NLO + a]);
                r_q_t2[a] <= f_sat(w_qhi[a], r_dl_side[QW-1][S_NHI + a]);
            end
            r_q_side <= r_dl_side[QW-1];
        end
    end

    // stage B: order each slab, neutral for parallel axes
    logic          r_b_valid;
    logic [W-1:0]  r_b_lo [3];
    logic [W-1:0]  r_b_hi [3];
    logic [SW-1:0] r_b_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                if (r_q_side[S_DZ + a]) begin
                    r_b_lo[a] <= TMIN;
                    r_b_hi[a] <= TMAX;
                end else if ($signed(r_q_t1[a]) > $signed(r_q_t2[a])) begin
                    r_b_lo[a] <= r_q_t2[a];
                    r_b_hi[a] <= r_q_t1[a];
                end else begin
                    r_b_lo[a] <= r_q_t1[a];
                    r_b_hi[a] <= r_q_t2[a];
                end
            end
            r_b_side <= r_q_side;
        end
    end

    // stage C: near / far
    logic          r_c_valid;
    logic [W-1:0]  r_c_near;
    logic [W-1:0]  r_c_far;
    logic [SW-1:0] r_c_side;
    logic [W-1:0]  n_near;
    logic [W-1:0]  n_far;

    always_comb begin
        n_near = r_b_lo[0];
        n_far  = r_b_hi[0];
        for (int a = 1; a < 3; a++) begin
            if ($signed(r_b_lo[a]) > $signed(n_near)) n_near = r_b_lo[a];
            if ($signed(r_b_hi[a]) < $signed(n_far))  n_far  = r_b_hi[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_near <= n_near;
            r_c_far  <= n_far;
            r_c_side <= r_b_side;
        end
    end

    // stages D, E: miss flag, hit point
    logic         r_d_valid;
    logic         r_d_miss;
    logic [W-1:0] r_d_near;
    logic         r_e_valid;
    logic         r_e_miss;
    logic [W-1:0] r_e_near;
    logic [W-1:0] w_pt [3];
    logic         n_miss;

    assign n_miss = r_c_side[S_FAIL] || ($signed(r_c_near) > $signed(r_c_far)) ||
                    ($signed(r_c_far) <= 0);

    for (genvar a = 0; a < 3; a++) begin : g_pt
        rbsi_hitpt #(.WORD_WIDTH(W), .FRAC_BITS(F)) u_hitpt (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_dir   (r_c_side[(3+a)*W +: W]),
            .i_near  (r_c_near),
            .i_orig  (r_c_side[a*W +: W]),
            .o_point (w_pt[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_miss <= n_miss;
            r_d_near <= r_c_near;
            r_e_miss <= r_d_miss;
            r_e_near <= r_d_near;
        end
    end

    // stage F: face and output word
    rbsi_pkg::t_face n_face;
    logic            r_o_valid;
    logic [OUT_TW-1:0] r_o_data;
    logic [OUT_TW-1:0] n_o_data;

    always_comb begin
        if (w_pt[2] == r_box_hi[2])      n_face = rbsi_pkg::FACE_POS_Z;
        else if (w_pt[2] == r_box_lo[2]) n_face = rbsi_pkg::FACE_NEG_Z;
        else if (w_pt[1] == r_box_hi[1]) n_face = rbsi_pkg::FACE_POS_Y;
        else if (w_pt[1] == r_box_lo[1]) n_face = rbsi_pkg::FACE_NEG_Y;
        else if (w_pt[0] == r_box_hi[0]) n_face = rbsi_pkg::FACE_POS_X;
        else if (w_pt[0] == r_box_lo[0]) n_face = rbsi_pkg::FACE_NEG_X;
        else                             n_face = rbsi_pkg::FACE_NONE;
    end

    always_comb begin
        n_o_data = '0;
        if (!r_e_miss) begin
            n_o_data[0]             = 1'b1;
            n_o_data[1 +: W]        = r_e_near;
            n_o_data[1 + W +: W]    = w_pt[0];
            n_o_data[1 + 2*W +: W]  = w_pt[1];
            n_o_data[1 + 3*W +: W]  = w_pt[2];
            n_o_data[1 + 4*W +: 3]  = n_face;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

endmodule

@@ bench/rbsi_checker.sv @@
// Checker for the ray / box slab intersection block: watches the config port and both
// streams, predicts each result from a local box copy and compares field by field.
// Depends on rbsi_pkg.
`timescale 1ns / 100ps

module rbsi_checker #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  rbsi_pkg::t_cfg_idx   i_cfg_idx,
    input  logic [WORD_WIDTH-1:0] i_cfg_data,
    input  logic                 i_s_axis_tvalid,
    input  logic                 i_s_axis_tready,
    // orig_x, orig_y, orig_z, dir_x, dir_y, dir_z
    input  logic [191:0]         i_s_axis_tdata,
    input  logic                 i_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // hit, t_entry, point_x, point_y, point_z, face, zero fill
    input  logic [135:0]         i_m_axis_tdata,
    output int                   o_fail_cnt,
    output int                   o_pending
);

    localparam longint W_MAX = 64'sd2147483647;
    localparam longint W_MIN = -64'sd2147483648;

    typedef struct {
        logic            hit;
        logic [31:0]     t_entry;
        logic [31:0]     px;
        logic [31:0]     py;
        logic [31:0]     pz;
        rbsi_pkg::t_face face;
    } t_hit_rec;

    longint   box_lo[3];
    longint   box_hi[3];
    t_hit_rec hit_q[$];

    function automatic longint clamp_word(longint v);
        if (v > W_MAX) return W_MAX;
        if (v < W_MIN) return W_MIN;
        return v;
    endfunction

    function automatic longint slab_div(longint num, longint den);
        longint unsigned na, da, q, lim;
        logic neg;
        na  = num < 0 ? -num : num;
        da  = den < 0 ? -den : den;
        neg = (num < 0) != (den < 0);
        lim = 64'd1 << 31;
        q   = (na << FRAC_BITS) / da;
        if (q > lim || (!neg && q == lim)) return neg ? W_MIN : W_MAX;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint unsigned ua, ub, p;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p  = (ua * ub) >> FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic t_hit_rec trace_ray(logic [191:0] ray);
        t_hit_rec r;
        longint o[3], d[3], p[3];
        longint tn, tf, t1, t2, s;
        r  = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, rbsi_pkg::FACE_NONE};
        tn = W_MIN;
        tf = W_MAX;
        for (int a = 0; a < 3; a++) begin
            o[a] = longint'($signed(ray[32*a +: 32]));
            d[a] = longint'($signed(ray[32*(a+3) +: 32]));
        end
        for (int a = 0; a < 3; a++) begin
            if (d[a] == 0) begin
                if (o[a] < box_lo[a] || o[a] > box_hi[a]) return r;
            end else begin
                t1 = slab_div(box_lo[a] - o[a], d[a]);
                t2 = slab_div(box_hi[a] - o[a], d[a]);
                if (t1 > t2) begin
                    s = t1; t1 = t2; t2 = s;
                end
                if (t1 > tn) tn = t1;
                if (t2 < tf) tf = t2;
                if (tn > tf || tf <= 0) return r;
            end
        end
        for (int a = 0; a < 3; a++) p[a] = clamp_word(o[a] + fx_mul(d[a], tn));
        if (p[2] == box_hi[2])      r.face = rbsi_pkg::FACE_POS_Z;
        else if (p[2] == box_lo[2]) r.face = rbsi_pkg::FACE_NEG_Z;
        else if (p[1] == box_hi[1]) r.face = rbsi_pkg::FACE_POS_Y;
        else if (p[1] == box_lo[1]) r.face = rbsi_pkg::FACE_NEG_Y;
        else if (p[0] == box_hi[0]) r.face = rbsi_pkg::FACE_POS_X;
        else if (p[0] == box_lo[0]) r.face = rbsi_pkg::FACE_NEG_X;
        r.hit     = 1'b1;
        r.t_entry = tn[31:0];
        r.px      = p[0][31:0];
        r.py      = p[1][31:0];
        r.pz      = p[2][31:0];
        return r;
    endfunction

    task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            o_fail_cnt++;
        end
    endtask

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        t_hit_rec want;
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                box_lo[a] = 0;
                box_hi[a] = 64'sd65536;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx <= rbsi_pkg::REG_LOW_Z)
                    box_lo[i_cfg_idx] = longint'($signed(i_cfg_data));
                else if (i_cfg_idx <= rbsi_pkg::REG_HIGH_Z)
                    box_hi[i_cfg_idx - rbsi_pkg::REG_HIGH_X] = longint'($signed(i_cfg_data));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (hit_q.size() == 0) begin
                    $error("result word with no ray outstanding: %h", i_m_axis_tdata);
                    o_fail_cnt++;
                end else begin
                    want = hit_q.pop_front();
                    cmp_field("hit", 32'(want.hit), 32'(i_m_axis_tdata[0]));
                    cmp_field("t_entry", want.t_entry, i_m_axis_tdata[32:1]);
                    cmp_field("point_x", want.px, i_m_axis_tdata[64:33]);
                    cmp_field("point_y", want.py, i_m_axis_tdata[96:65]);
                    cmp_field("point_z", want.pz, i_m_axis_tdata[128:97]);
                    cmp_field("face", 32'(want.face), 32'(i_m_axis_tdata[131:129]));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) hit_q.push_back(trace_ray(i_s_axis_tdata));
        end
        o_pending = hit_q.size();
    end

endmodule

@@ bench/tb_ray_box_slab_intersect.sv @@
// Testbench top for ray_box_slab_intersect: drives rays and box settings with random
// gaps and stalls; rbsi_checker predicts and compares. Depends on rbsi_pkg, rbsi_checker.
`timescale 1ns / 100ps

module tb_ray_box_slab_intersect;

    localparam int LATENCY = 56;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] W_MAX = 32'h7fff_ffff;
    localparam logic [31:0] W_MIN = 32'h8000_0000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    rbsi_pkg::t_cfg_idx cfg_idx = rbsi_pkg::REG_LOW_X;
    logic [31:0]        cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [191:0]       s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [135:0]       m_tdata;
    int                 fail_cnt, pending;
    logic               rx_hold = 1'b0;
    logic               steady = 1'b0;
    logic [31:0]        box[6];

    always #5 i_clk = ~i_clk;

    ray_box_slab_intersect dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata)
    );

    rbsi_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .i_m_axis_tdata(m_tdata),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    initial begin
        #20ms;
        $display("FAIL ray_box_slab_intersect");
        $finish;
    end

    // receiver: random stalls per word, one long hold-off on request
    initial begin
        int n;
        forever begin
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            n = steady ? 0 : $urandom_range(0, 9);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk iff (m_tvalid && m_tready));
        end
    end

    task automatic send_ray(logic [191:0] ray);
        int n;
        n = steady ? 0 : $urandom_range(0, 9);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ray;
        @(posedge i_clk iff (s_tvalid && s_tready));
    endtask

    // let the checker count the last accepted ray before waiting for pending to clear
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    task automatic drain();
        wait_idle();
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic load_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                            logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
        box = '{lx, ly, lz, hx, hy, hz};
        for (int i = 0; i < 6; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= rbsi_pkg::t_cfg_idx'(i);
            cfg_data <= box[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [191:0] pack_ray(logic [31:0] ox, logic [31:0] oy,
            logic [31:0] oz, logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        return {dz, dy, dx, oz, oy, ox};
    endfunction

    // mostly rays aimed at a point inside the box from an origin near it
    function automatic logic [191:0] random_ray();
        logic [31:0] o[3], d[3];
        longint lo, hi, tgt;
        int kind;
        kind = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++) begin
            lo = longint'($signed(box[a]));
            hi = longint'($signed(box[a+3]));
            if (hi < lo) hi = lo;
            tgt  = lo + longint'({$urandom, $urandom} % (longint'(hi - lo) + 1));
            o[a] = 32'(tgt + $signed($urandom_range(0, 8 << 16)) - (4 << 16));
            d[a] = 32'(tgt) - o[a];
            if ($urandom_range(0, 3) == 0) d[a] = d[a] >>> $urandom_range(0, 12);
        end
        if (kind < 2) d[$urandom_range(0, 2)] = '0;
        if (kind == 2) begin
            d[$urandom_range(0, 2)] = '0;
            d[$urandom_range(0, 2)] = '0;
        end
        if (kind == 3) return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (kind == 4) o[$urandom_range(0, 2)] = $urandom;
        return pack_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) send_ray(random_ray());
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        box = '{32'd0, 32'd0, 32'd0, Q_ONE, Q_ONE, Q_ONE};

        // directed, reset box
        send_ray(pack_ray(32'h8000, 32'h8000, 32'h8000, 0, 0, 0));
        send_ray(pack_ray(32'h8000, 32'h8000, -Q_ONE, 0, 0, Q_ONE));
        send_ray(pack_ray(32'h8000, 32'h8000, 2 * Q_ONE, 0, 0, -Q_ONE));
        send_ray(pack_ray(32'h8000, -Q_ONE, 32'h8000, 0, Q_ONE, 0));
        send_ray(pack_ray(32'h8000, 3 * Q_ONE, 32'h8000, 0, -Q_ONE, 0));
        send_ray(pack_ray(-Q_ONE, 32'h8000, 32'h8000, Q_ONE, 0, 0));
        send_ray(pack_ray(2 * Q_ONE, 32'h8000, 32'h8000, -Q_ONE, 0, 0));
        send_ray(pack_ray(32'h8000, 32'h8000, 32'h8000, Q_ONE, Q_ONE, Q_ONE));
        send_ray(pack_ray(2 * Q_ONE, 32'h8000, 32'h8000, Q_ONE, 0, 0));
        send_ray(pack_ray(32'h8000, 32'h8000, 2 * Q_ONE, 0, 0, 0));
        send_ray(pack_ray(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX));
        send_ray(pack_ray(W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN));
        send_ray(pack_ray(-Q_ONE, 32'h8000, 32'h8000, 32'd1, 0, 0));
        send_ray(pack_ray(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, 32'h0001_0001));
        send_ray(pack_ray(32'h8000, 32'h8000, 32'h8000, 32'h0, W_MIN, 32'h0));
        send_ray(pack_ray(32'h0, 32'h0, 32'h0, W_MAX, 32'd1, W_MIN));
        drain();

        // widest box, saturation of slab distances
        load_box(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX);
        send_ray(pack_ray(0, 0, 0, 32'd1, 32'd1, 32'd1));
        send_ray(pack_ray(W_MAX, 0, 0, W_MIN, 0, 0));
        send_ray(pack_ray(W_MIN, W_MIN, W_MIN, 32'd1, 0, 0));
        random_phase(40);
        drain();

        // inverted box, receiver long hold-off while sender keeps going
        load_box(Q_ONE, -Q_ONE, 2 * Q_ONE, -Q_ONE, Q_ONE, -Q_ONE);
        send_ray(pack_ray(0, 0, 0, 0, Q_ONE, Q_ONE));
        rx_hold = 1'b1;
        random_phase(90);
        drain();

        // zero-thickness box
        load_box(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        random_phase(60);
        drain();

        // mid-size box, back to back with no idling, pause mid-phase
        load_box(-8 * Q_ONE, -3 * Q_ONE, 32'hfffe_8000, 5 * Q_ONE, 7 * Q_ONE, 32'h0002_4000);
        steady = 1'b1;
        random_phase(80);
        steady = 1'b0;
        wait_idle();
        random_phase(80);
        drain();

        // random boxes
        for (int k = 0; k < 3; k++) begin
            load_box(-$urandom_range(0, 1 << 20), -$urandom_range(0, 1 << 20),
                     -$urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                     $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20));
            random_phase(50);
            drain();
        end

        if (fail_cnt == 0 && pending == 0) begin
            $display("PASS ray_box_slab_intersect");
        end else begin
            $display("FAIL ray_box_slab_intersect");
        end
        $finish;
    end

endmodule
